// ===== rtl/crc32_byte_stream_top_macros.svh =====
// Assertion macros shared by the CRC-32 byte stream RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef CRC32_BYTE_STREAM_TOP_MACROS_SVH
`define CRC32_BYTE_STREAM_TOP_MACROS_SVH

// same-cycle implication
`define CRCBS_ASSERT_IMP(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// next-cycle implication
`define CRCBS_ASSERT_NXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

// ===== rtl/crcbs_pkg.sv =====
// Package for the CRC-32 byte stream block: item types, command codes, byte fold.
// No dependencies.
`default_nettype none

package crcbs_pkg;

	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

	typedef enum logic {
		CMD_DATA   = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	typedef struct packed {
		logic       valid;
		cmd_t       command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] byte_count;
		logic [31:0] crc_value;
	} result_t;

	// reflected CRC-32, one byte, eight shift/xor steps
	function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] lo;
		lo = {24'h0, acc[7:0] ^ b};
		for (int i = 0; i < 8; i++) begin
			lo = lo[0] ? ((lo >> 1) ^ CRC_POLY) : (lo >> 1);
		end
		return {8'h0, acc[31:8]} ^ lo;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crc32_byte_stream_top.sv =====
// CRC-32 byte stream: one item per cycle while the input is not stalled; a finish
// item passes the input register, then its result is loaded into the result
// register, from which the output stream offers it.
// The byte fold is an unrolled eight-step XOR network between the input register and the accumulator.
// Input stalls only when a finish meets a full result register that is not taken.
// Reset (arst_n low) clears valid flags, accumulator, byte count and start value.
`default_nettype none

module crc32_byte_stream_top
	import crcbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [31:0] crc_value, [63:32] byte_count
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data        // start_value
);

	item_t   item_s1;
	logic    advance;
	logic    out_free;
	logic    res_load;
	result_t res;

	crcbs_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.advance       (advance),
		.item_s1       (item_s1)
	);

	crcbs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.advance   (advance),
		.res_load  (res_load),
		.res       (res)
	);

	crcbs_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_load      (res_load),
		.res           (res),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/crcbs_in_stage.sv =====
// Input register of the CRC-32 byte stream block.
// Depends on crcbs_pkg.
`default_nettype none

module crcbs_in_stage
	import crcbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tuser,   // [0] command
	input  wire logic       advance,
	output item_t           item_s1
);

	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] byte_s1;

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		item_s1.valid     = valid_s1;
		item_s1.command   = cmd_s1;
		item_s1.data_byte = byte_s1;
	end

endmodule

`default_nettype wire

// ===== rtl/crcbs_core.sv =====
// CRC accumulator, byte counter and start value register.
// Depends on crcbs_pkg and crc32_byte_stream_top_macros.svh.
`default_nettype none
`include "crc32_byte_stream_top_macros.svh"

module crcbs_core
	import crcbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire item_t       item_s1,
	input  wire logic        out_free,
	output logic             advance,
	output logic             res_load,
	output result_t          res
);

	logic [31:0] start_q;
	logic [31:0] acc_q;
	logic [31:0] bytes_q;
	logic        is_finish;

	assign cfg_ready = 1'b1;
	assign is_finish = (item_s1.command == CMD_FINISH);
	assign advance   = item_s1.valid && (!is_finish || out_free);
	assign res_load  = item_s1.valid && is_finish && out_free;

	always_comb begin
		res.crc_value  = acc_q ^ CRC_XOROUT;
		res.byte_count = bytes_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			bytes_q <= '0;
		end else if (advance) begin
			if (is_finish) begin
				acc_q   <= start_q;
				bytes_q <= '0;
			end else begin
				acc_q   <= crc_fold(acc_q, item_s1.data_byte);
				bytes_q <= bytes_q + 32'd1;
			end
		end
	end

	`CRCBS_ASSERT_NXT(a_finish_clears, advance && is_finish, bytes_q == 32'd0, "count not cleared")
	`CRCBS_ASSERT_NXT(a_finish_reload, advance && is_finish, acc_q == $past(start_q), "acc not reloaded")
	`CRCBS_ASSERT_NXT(a_fold_count, advance && !is_finish, bytes_q == $past(bytes_q) + 32'd1, "count step")
	`CRCBS_ASSERT_NXT(a_hold, !advance, $stable(acc_q) && $stable(bytes_q), "state moved while stalled")
	`CRCBS_ASSERT_IMP(a_load_free, res_load, out_free && advance, "result loaded into busy register")

endmodule

`default_nettype wire

// ===== rtl/crcbs_out_stage.sv =====
// Result register of the CRC-32 byte stream block, master side of the stream.
// Depends on crcbs_pkg.
`default_nettype none

module crcbs_out_stage
	import crcbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        res_load,
	input  wire result_t     res,
	output logic             out_free,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata   // [31:0] crc_value, [63:32] byte_count
);

	logic    valid_s2;
	result_t res_s2;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.byte_count, res_s2.crc_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for crc32_byte_stream_top: a directed table, then random
// messages under four sender/receiver idle mixes, scored against a bitwise CRC-32 predictor.
// Depends on crcbs_pkg (command codes, polynomial, output inversion) and the RTL.
module tb_top;
	import crcbs_pkg::*;

	localparam int RESULT_LATENCY = 2;
	localparam int SETTLE_CYCLES = 2 * RESULT_LATENCY;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 325;

	typedef enum logic [1:0] {
		ROW_DATA,
		ROW_FINISH,
		ROW_START_WRITE
	} row_kind_t;

	// value: start value for ROW_START_WRITE, expected crc_value for a typed ROW_FINISH
	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  byte_in;
		logic [31:0] value;
		logic        typed;
		logic [31:0] count;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] crc;
		logic [31:0] count;
	} crc_report_t;

	localparam stim_row_t DIRECTED_ROWS [26] = '{
		'{ROW_FINISH,      8'h00, 32'hFFFF_FFFF, 1'b1, 32'd0},
		'{ROW_DATA,        8'h00, 32'h0,         1'b0, 32'd0},
		'{ROW_FINISH,      8'h00, 32'hFFFF_FFFF, 1'b1, 32'd1},
		'{ROW_DATA,        8'hFF, 32'h0,         1'b0, 32'd0},
		'{ROW_FINISH,      8'hFF, 32'hD2FD_1072, 1'b1, 32'd1},
		'{ROW_START_WRITE, 8'h00, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{ROW_FINISH,      8'hA5, 32'hFFFF_FFFF, 1'b1, 32'd0},
		'{ROW_FINISH,      8'h00, 32'h0000_0000, 1'b1, 32'd0},
		'{ROW_DATA,        8'h31, 32'h0,         1'b0, 32'd0},
		'{ROW_DATA,        8'h32, 32'h0,         1'b0, 32'd0},
		'{ROW_DATA,        8'h33, 32'h0,         1'b0, 32'd0},
		'{ROW_DATA,        8'h34, 32'h0,         1'b0, 32'd0},
		'{ROW_DATA,        8'h35, 32'h0,         1'b0, 32'd0},
		'{ROW_DATA,        8'h36, 32'h0,         1'b0, 32'd0},
		'{ROW_DATA,        8'h37, 32'h0,         1'b0, 32'd0},
		'{ROW_DATA,        8'h38, 32'h0,         1'b0, 32'd0},
		'{ROW_DATA,        8'h39, 32'h0,         1'b0, 32'd0},
		'{ROW_FINISH,      8'h5C, 32'hCBF4_3926, 1'b1, 32'd9},
		'{ROW_DATA,        8'h5A, 32'h0,         1'b0, 32'd0},
		'{ROW_START_WRITE, 8'h00, 32'h1234_5678, 1'b0, 32'd0},
		'{ROW_DATA,        8'hC3, 32'h0,         1'b0, 32'd0},
		'{ROW_FINISH,      8'h80, 32'h0,         1'b0, 32'd0},
		'{ROW_FINISH,      8'h00, 32'hEDCB_A987, 1'b1, 32'd0},
		'{ROW_START_WRITE, 8'h00, 32'h0000_0000, 1'b0, 32'd0},
		'{ROW_FINISH,      8'h00, 32'hEDCB_A987, 1'b1, 32'd0},
		'{ROW_FINISH,      8'hFF, 32'hFFFF_FFFF, 1'b1, 32'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tuser;   // [0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // [31:0] crc_value, [63:32] byte_count
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	// predictor state
	logic [31:0] crc_acc;
	logic [31:0] byte_tally;
	logic [31:0] start_reg;
	crc_report_t crc_reports_due[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int          mismatches;
	int          quiet_cycles;
	int          items_sent;
	int          finishes_sent;
	int          reports_checked;
	int          start_writes;

	crc32_byte_stream_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit roll(input int unsigned pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic logic [31:0] crc_byte_step(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
		end
		return r;
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%t: %s", $realtime, msg);
		end
	endtask

	task automatic check_report(input logic [63:0] word);
		crc_report_t want;
		logic [31:0] got_crc;
		logic [31:0] got_count;
		got_crc = word[31:0];
		got_count = word[63:32];
		reports_checked++;
		if (crc_reports_due.size() == 0) begin
			flag($sformatf("unexpected report crc %08h count %0d", got_crc, got_count));
		end else begin
			want = crc_reports_due.pop_front();
			if (got_crc !== want.crc) begin
				flag($sformatf("report %0d crc_value: expected %08h, got %08h",
					reports_checked, want.crc, got_crc));
			end
			if (got_count !== want.count) begin
				flag($sformatf("report %0d byte_count: expected %0d, got %0d",
					reports_checked, want.count, got_count));
			end
		end
	endtask

	// result side: random stall, scoring, watchdog
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			check_report(m_axis_tdata);
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		m_axis_tready <= !roll(recv_stall_pct);
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(input cmd_t c, input logic [7:0] b, input bit typed,
			input logic [31:0] typed_crc, input logic [31:0] typed_count);
		crc_report_t due;
		while (roll(send_idle_pct)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= c;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		items_sent++;
		if (c == CMD_DATA) begin
			crc_acc = crc_byte_step(crc_acc, b);
			byte_tally = byte_tally + 32'd1;
		end else begin
			due.crc = typed ? typed_crc : (crc_acc ^ CRC_XOROUT);
			due.count = typed ? typed_count : byte_tally;
			crc_reports_due.push_back(due);
			crc_acc = start_reg;
			byte_tally = 32'd0;
			finishes_sent++;
		end
	endtask

	task automatic drain_reports();
		s_axis_tvalid <= 1'b0;
		while (crc_reports_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_start(input logic [31:0] v);
		drain_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		start_reg = v;
		start_writes++;
	endtask

	initial begin
		int unsigned msg_len;
		int          phase_items;
		bit          paused;
		logic [31:0] next_start;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tuser <= CMD_DATA;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= 32'h0;
		crc_acc = 32'h0;
		byte_tally = 32'h0;
		start_reg = 32'h0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		items_sent = 0;
		finishes_sent = 0;
		reports_checked = 0;
		start_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			case (DIRECTED_ROWS[i].kind)
				ROW_DATA: begin
					send_item(CMD_DATA, DIRECTED_ROWS[i].byte_in, 1'b0, 32'h0, 32'h0);
				end
				ROW_FINISH: begin
					send_item(CMD_FINISH, DIRECTED_ROWS[i].byte_in, DIRECTED_ROWS[i].typed,
						DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].count);
				end
				default: begin
					write_start(DIRECTED_ROWS[i].value);
				end
			endcase
		end

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: next_start = $urandom;
				1: next_start = 32'hFFFF_FFFF;
				2: next_start = 32'h0000_0000;
				default: next_start = $urandom;
			endcase
			// leave a partial message in the accumulator across the write
			repeat ($urandom_range(3, 0))
				send_item(CMD_DATA, 8'($urandom_range(255, 0)), 1'b0, 32'h0, 32'h0);
			write_start(next_start);
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			phase_items = 0;
			paused = 1'b0;
			while (phase_items < PHASE_ITEMS) begin
				msg_len = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 13)
					: $urandom_range(12, 0);
				repeat (msg_len)
					send_item(CMD_DATA, 8'($urandom_range(255, 0)), 1'b0, 32'h0, 32'h0);
				send_item(CMD_FINISH, 8'($urandom_range(255, 0)), 1'b0, 32'h0, 32'h0);
				phase_items += msg_len + 1;
				if (!paused && phase_items >= PHASE_ITEMS / 2) begin
					drain_reports();
					paused = 1'b1;
				end
			end
		end

		drain_reports();
		repeat (4 * RESULT_LATENCY) @(posedge clk);
		$display("covered %0d stream items, %0d finishes, %0d start value writes",
			items_sent, finishes_sent, start_writes);
		$display("%0d CRC reports scored across four idle/stall mixes, %0d mismatches",
			reports_checked, mismatches);
		if (mismatches == 0 && crc_reports_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== crc32_byte_stream_top.f =====
+incdir+rtl
rtl/crcbs_pkg.sv
rtl/crcbs_in_stage.sv
rtl/crcbs_core.sv
rtl/crcbs_out_stage.sv
rtl/crc32_byte_stream_top.sv
sim/tb_top.sv
